// ----- sv/ecr_pkg.sv -----
// ----------------------------------------------------------------------------
// ecr_pkg
// widths and the division stage record shared by the collision response core
// ----------------------------------------------------------------------------
package ecr_pkg;

    localparam int AXW    = 32;               // one q16.16 component
    localparam int NAX    = 3;                // axes
    localparam int NCOR   = 2 * NAX;          // corrections, body one then body two
    localparam int NIN    = 11;               // input fields
    localparam int IN_W   = NIN * AXW;        // s_tdata width
    localparam int OUT_W  = NCOR * AXW;       // m_tdata width
    localparam int DIFW   = AXW + 1;          // v2 - v1
    localparam int PRW    = AXW + DIFW;       // d * (v2 - v1)
    localparam int PW     = PRW + 1;          // dot product, three terms
    localparam int PHW    = PW / 2;           // half of the dot product magnitude
    localparam int SQW    = 2 * AXW;          // |d|^2
    localparam int TOTW   = AXW + 1;          // m1 + m2
    localparam int MDW    = 2 * AXW;          // m * |d_i|
    localparam int DPW    = AXW + TOTW;       // one partial of |d|^2 * (m1 + m2)
    localparam int DENW   = SQW + TOTW;       // |d|^2 * (m1 + m2)
    localparam int PPW    = PHW + AXW;        // one partial of the numerator
    localparam int NW     = PW + MDW + 1;     // numerator, with the factor two
    localparam int QW     = NW - DENW;        // quotient bits below the cap
    localparam int CMW    = QW + 1;           // correction magnitude
    localparam int SUMW   = CMW + 2;          // velocity plus correction

    typedef struct packed {
        logic [DENW-1:0]           den;
        logic [NCOR-1:0][NW-1:0]   rem;
        logic [NCOR-1:0][QW-1:0]   quo;
        logic [NCOR-1:0]           ovf;
        logic [NCOR-1:0]           neg;
        logic [NAX-1:0][AXW-1:0]   v1;
        logic [NAX-1:0][AXW-1:0]   v2;
        logic                      degen;
    } div_t;

endpackage

// ----- sv/elastic_collision_response_core.sv -----
// ----------------------------------------------------------------------------
// elastic_collision_response_core
// 3d elastic collision of two bodies in q16.16, exact single-division form
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)                        | tuser
//  s_      | in  | delta_x/y/z, vel_one_x/y/z, vel_two_x/y/z, mass_one/two | -
//  m_      | out | new_one_x/y/z, new_two_x/y/z                          | degenerate
//
//  one item per cycle unless the output stalls. the pipe has five arithmetic
//  stages, a compare stage, 34 restoring division stages (one quotient bit
//  each, six dividers side by side) and the output register.
//  every stage holds a valid bit; a stage loads when it is empty or the next
//  one moves, so bubbles close up and a stalled output keeps all items.
//  reset clears only the valid bits.
module elastic_collision_response_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // delta_x, delta_y, delta_z, vel_one_x..z, vel_two_x..z, mass_one, mass_two
    input  logic [ecr_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // new_one_x, new_one_y, new_one_z, new_two_x, new_two_y, new_two_z
    output logic [ecr_pkg::OUT_W-1:0] m_tdata,
    // degenerate
    output logic                      m_tuser
);
    import ecr_pkg::*;

    localparam int NST   = QW + 7;
    localparam int DIV0  = 5;

    logic [NST-1:0] vld_reg, vld_next;
    logic [NST:0]   en;

    // stage 1
    logic [NAX-1:0][PRW-1:0] s1_prod_reg, s1_prod_next;
    logic [NAX-1:0][SQW-1:0] s1_dsq_reg, s1_dsq_next;
    logic [TOTW-1:0]         s1_tot_reg, s1_tot_next;
    logic [NCOR-1:0][MDW-1:0] s1_md_reg, s1_md_next;
    logic [NAX-1:0]          s1_dneg_reg, s1_dneg_next;
    logic [NAX-1:0][AXW-1:0] s1_v1_reg, s1_v2_reg, in_v1, in_v2;
    // stage 2
    logic signed [PW-1:0]    s2_p_reg, s2_p_next;
    logic [SQW-1:0]          s2_sq_reg, s2_sq_next;
    logic [TOTW-1:0]         s2_tot_reg;
    logic [NCOR-1:0][MDW-1:0] s2_md_reg;
    logic [NAX-1:0]          s2_dneg_reg;
    logic [NAX-1:0][AXW-1:0] s2_v1_reg, s2_v2_reg;
    // stage 3
    logic [PW-1:0]           s3_pmag_reg, s3_pmag_next;
    logic [DPW-1:0]          s3_dlo_reg, s3_dlo_next, s3_dhi_reg, s3_dhi_next;
    logic                    s3_degen_reg, s3_degen_next;
    logic [NCOR-1:0]         s3_neg_reg, s3_neg_next;
    logic [NCOR-1:0][MDW-1:0] s3_md_reg;
    logic [NAX-1:0][AXW-1:0] s3_v1_reg, s3_v2_reg;
    // stage 4
    logic [DENW-1:0]         s4_den_reg, s4_den_next;
    logic [NCOR-1:0][3:0][PPW-1:0] s4_pp_reg, s4_pp_next;
    logic                    s4_degen_reg;
    logic [NCOR-1:0]         s4_neg_reg;
    logic [NAX-1:0][AXW-1:0] s4_v1_reg, s4_v2_reg;
    // stage 5
    logic [NCOR-1:0][NW-1:0] s5_n_reg, s5_n_next;
    logic [DENW-1:0]         s5_den_reg;
    logic                    s5_degen_reg;
    logic [NCOR-1:0]         s5_neg_reg;
    logic [NAX-1:0][AXW-1:0] s5_v1_reg, s5_v2_reg;
    // compare and division
    div_t                    div_reg [0:QW];
    div_t                    div0_next;
    // output
    logic [OUT_W-1:0]        out_data_reg, out_data_next;
    logic                    out_degen_reg;

    // stall chain: a stage moves when empty or when its successor moves
    always_comb begin
        en[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
                vld_next[k] = vld_reg[k-1];
            end else begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: products of the dot terms, squares, mass times |d_i|
    always_comb begin
        logic signed [AXW-1:0]  d;
        logic signed [DIFW-1:0] diff;
        logic [AXW-1:0]         dmag;
        logic [AXW-1:0]         m1, m2;
        m1 = s_tdata[9*AXW +: AXW];
        m2 = s_tdata[10*AXW +: AXW];
        s1_tot_next = TOTW'(m1) + TOTW'(m2);
        for (int c = 0; c < NAX; c++) begin
            d        = $signed(s_tdata[c*AXW +: AXW]);
            in_v1[c] = s_tdata[(NAX+c)*AXW +: AXW];
            in_v2[c] = s_tdata[(2*NAX+c)*AXW +: AXW];
            diff = $signed({in_v2[c][AXW-1], in_v2[c]}) - $signed({in_v1[c][AXW-1], in_v1[c]});
            s1_prod_next[c] = PRW'(d) * PRW'(diff);
            s1_dsq_next[c]  = SQW'(d) * SQW'(d);
            s1_dneg_next[c] = d[AXW-1];
            dmag = d[AXW-1] ? AXW'(-d) : d;
            s1_md_next[c]     = MDW'(m2) * MDW'(dmag);
            s1_md_next[NAX+c] = MDW'(m1) * MDW'(dmag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_prod_reg <= s1_prod_next;
            s1_dsq_reg  <= s1_dsq_next;
            s1_tot_reg  <= s1_tot_next;
            s1_md_reg   <= s1_md_next;
            s1_dneg_reg <= s1_dneg_next;
            s1_v1_reg   <= in_v1;
            s1_v2_reg   <= in_v2;
        end
    end

    // stage 2: dot product and squared length
    always_comb begin
        s2_p_next  = PW'($signed(s1_prod_reg[0])) + PW'($signed(s1_prod_reg[1]))
                   + PW'($signed(s1_prod_reg[2]));
        s2_sq_next = s1_dsq_reg[0] + s1_dsq_reg[1] + s1_dsq_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_p_reg    <= s2_p_next;
            s2_sq_reg   <= s2_sq_next;
            s2_tot_reg  <= s1_tot_reg;
            s2_md_reg   <= s1_md_reg;
            s2_dneg_reg <= s1_dneg_reg;
            s2_v1_reg   <= s1_v1_reg;
            s2_v2_reg   <= s1_v2_reg;
        end
    end

    // stage 3: magnitude and signs, denominator partials
    always_comb begin
        s3_pmag_next  = s2_p_reg[PW-1] ? PW'(-s2_p_reg) : PW'(s2_p_reg);
        s3_dlo_next   = DPW'(s2_sq_reg[AXW-1:0]) * DPW'(s2_tot_reg);
        s3_dhi_next   = DPW'(s2_sq_reg[SQW-1:AXW]) * DPW'(s2_tot_reg);
        s3_degen_next = (s2_sq_reg == '0) || (s2_tot_reg == '0);
        for (int c = 0; c < NAX; c++) begin
            s3_neg_next[c]     = s2_p_reg[PW-1] ^ s2_dneg_reg[c];
            s3_neg_next[NAX+c] = !s2_p_reg[PW-1] ^ s2_dneg_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s3_pmag_reg  <= s3_pmag_next;
            s3_dlo_reg   <= s3_dlo_next;
            s3_dhi_reg   <= s3_dhi_next;
            s3_degen_reg <= s3_degen_next;
            s3_neg_reg   <= s3_neg_next;
            s3_md_reg    <= s2_md_reg;
            s3_v1_reg    <= s2_v1_reg;
            s3_v2_reg    <= s2_v2_reg;
        end
    end

    // stage 4: denominator, numerator partial products
    always_comb begin
        s4_den_next = DENW'(s3_dlo_reg) + (DENW'(s3_dhi_reg) << AXW);
        for (int c = 0; c < NCOR; c++) begin
            s4_pp_next[c][0] = PPW'(s3_pmag_reg[PHW-1:0])  * PPW'(s3_md_reg[c][AXW-1:0]);
            s4_pp_next[c][1] = PPW'(s3_pmag_reg[PHW-1:0])  * PPW'(s3_md_reg[c][MDW-1:AXW]);
            s4_pp_next[c][2] = PPW'(s3_pmag_reg[PW-1:PHW]) * PPW'(s3_md_reg[c][AXW-1:0]);
            s4_pp_next[c][3] = PPW'(s3_pmag_reg[PW-1:PHW]) * PPW'(s3_md_reg[c][MDW-1:AXW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s4_den_reg   <= s4_den_next;
            s4_pp_reg    <= s4_pp_next;
            s4_degen_reg <= s3_degen_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_v1_reg    <= s3_v1_reg;
            s4_v2_reg    <= s3_v2_reg;
        end
    end

    // stage 5: numerators 2 * |p| * m * |d_i|
    always_comb begin
        for (int c = 0; c < NCOR; c++) begin
            s5_n_next[c] = (NW'(s4_pp_reg[c][0])
                          + (NW'(s4_pp_reg[c][1]) << AXW)
                          + (NW'(s4_pp_reg[c][2]) << PHW)
                          + (NW'(s4_pp_reg[c][3]) << (PHW + AXW))) << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s5_n_reg     <= s5_n_next;
            s5_den_reg   <= s4_den_reg;
            s5_degen_reg <= s4_degen_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_v1_reg    <= s4_v1_reg;
            s5_v2_reg    <= s4_v2_reg;
        end
    end

    // quotient at or above 2^QW means the correction is capped
    always_comb begin
        div0_next.den   = s5_den_reg;
        div0_next.rem   = s5_n_reg;
        div0_next.quo   = '0;
        div0_next.neg   = s5_neg_reg;
        div0_next.v1    = s5_v1_reg;
        div0_next.v2    = s5_v2_reg;
        div0_next.degen = s5_degen_reg;
        for (int c = 0; c < NCOR; c++) begin
            div0_next.ovf[c] = s5_n_reg[c] >= (NW'(s5_den_reg) << QW);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[DIV0]) begin
            div_reg[0] <= div0_next;
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar g = 0; g < QW; g++) begin : g_div
        localparam int K = QW - 1 - g;
        div_t step_next;

        always_comb begin
            logic [NW-1:0] sh;
            sh = NW'(div_reg[g].den) << K;
            step_next = div_reg[g];
            for (int c = 0; c < NCOR; c++) begin
                if (div_reg[g].rem[c] >= sh) begin
                    step_next.rem[c]    = div_reg[g].rem[c] - sh;
                    step_next.quo[c][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[DIV0+g+1]) begin
                div_reg[g+1] <= step_next;
            end
        end
    end

    // apply signed corrections, saturate, degenerate bypass
    always_comb begin
        logic [CMW-1:0]         cm;
        logic signed [SUMW-1:0] sv, sum;
        logic [AXW-1:0]         v;
        for (int c = 0; c < NCOR; c++) begin
            v  = (c < NAX) ? div_reg[QW].v1[c % NAX] : div_reg[QW].v2[c % NAX];
            cm = div_reg[QW].ovf[c] ? (CMW'(1) << QW) : CMW'(div_reg[QW].quo[c]);
            sv = SUMW'($signed(v));
            if (div_reg[QW].neg[c]) begin
                sum = sv - $signed(SUMW'(cm));
            end else begin
                sum = sv + $signed(SUMW'(cm));
            end
            if (div_reg[QW].degen) begin
                out_data_next[c*AXW +: AXW] = v;
            end else if (sum[SUMW-1:AXW-1] == '0 || sum[SUMW-1:AXW-1] == '1) begin
                out_data_next[c*AXW +: AXW] = sum[AXW-1:0];
            end else if (sum[SUMW-1]) begin
                out_data_next[c*AXW +: AXW] = {1'b1, {(AXW-1){1'b0}}};
            end else begin
                out_data_next[c*AXW +: AXW] = {1'b0, {(AXW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            out_data_reg  <= out_data_next;
            out_degen_reg <= div_reg[QW].degen;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks the 3d elastic collision core item by item against a full-width
// predictor, using directed corner cases and random pairs under random idling
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ecr_pkg::*;

    typedef logic [NIN-1:0][AXW-1:0]  pair_t;
    typedef logic [NCOR-1:0][AXW-1:0] vel_t;
    typedef logic [191:0]             wide_t;

    typedef struct {
        vel_t vel;
        logic degen;
    } response_t;

    localparam int FLD_M1  = 9;
    localparam int FLD_M2  = 10;
    localparam int LATENCY = 41;
    localparam int LIMIT   = 400000;

    class collision_scoreboard;
        response_t pending_q[$];
        int        n_errors;

        // correction along one axis, truncated toward zero and capped at 2^34
        function automatic longint axis_correction(wide_t pmag, bit pneg,
                                                   logic [31:0] m, longint di,
                                                   wide_t den);
            wide_t  num;
            wide_t  quo;
            longint dmag;
            longint val;
            bit     neg;
            if (di == 0) return 0;
            dmag = (di < 0) ? -di : di;
            neg  = pneg != (di < 0);
            num  = pmag;
            num  = num * wide_t'(m);
            num  = num << 1;
            num  = num * wide_t'(dmag);
            quo  = num / den;
            if (quo >= (wide_t'(1) << 34)) val = longint'(1) << 34;
            else val = longint'(quo[63:0]);
            return neg ? -val : val;
        endfunction

        function automatic logic [31:0] clamp(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function automatic response_t collide(pair_t it);
            response_t          r;
            longint             d [NAX];
            longint             v1[NAX];
            longint             v2[NAX];
            logic [63:0]        sq;
            logic [32:0]        tot;
            logic signed [127:0] dot;
            wide_t              pmag;
            wide_t              den;
            bit                 pneg;
            sq  = '0;
            dot = '0;
            tot = {1'b0, it[FLD_M1]} + {1'b0, it[FLD_M2]};
            for (int i = 0; i < NAX; i++) begin
                d[i]  = longint'(signed'(it[i]));
                v1[i] = longint'(signed'(it[NAX + i]));
                v2[i] = longint'(signed'(it[2*NAX + i]));
                sq    = sq + 64'(d[i] * d[i]);
                dot   = dot + 128'(d[i] * (v2[i] - v1[i]));
            end
            if (sq == 0 || tot == 0) begin
                for (int i = 0; i < NAX; i++) begin
                    r.vel[i]       = it[NAX + i];
                    r.vel[NAX + i] = it[2*NAX + i];
                end
                r.degen = 1'b1;
                return r;
            end
            pneg = dot < 0;
            pmag = wide_t'(pneg ? -dot : dot);
            den  = wide_t'(sq) * wide_t'(tot);
            for (int i = 0; i < NAX; i++) begin
                r.vel[i] = clamp(v1[i] +
                    axis_correction(pmag, pneg, it[FLD_M2], d[i], den));
                r.vel[NAX + i] = clamp(v2[i] +
                    axis_correction(pmag, !pneg, it[FLD_M1], d[i], den));
            end
            r.degen = 1'b0;
            return r;
        endfunction

        function void note_pair(pair_t it);
            pending_q.push_back(collide(it));
        endfunction

        function void check_response(vel_t vel, logic degen);
            response_t exp_r;
            bit        bad;
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h / %b", vel, degen);
                return;
            end
            exp_r = pending_q.pop_front();
            bad   = exp_r.degen !== degen;
            for (int i = 0; i < NCOR; i++)
                if (exp_r.vel[i] !== vel[i]) bad = 1;
            if (bad) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("mismatch: expected vel %h degen %b", exp_r.vel, exp_r.degen);
                    $display("          actual   vel %h degen %b", vel, degen);
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    pair_t       s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    vel_t        m_tdata;
    logic        m_tuser;

    collision_scoreboard sb = new();
    int tx_idle    = 27;
    int rx_idle    = 47;
    int stall_left = 0;
    int cycles     = 0;

    elastic_collision_response_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: long hold-off when asked, random stalls otherwise
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_response(m_tdata, m_tuser);
    end

    task automatic send_pair(pair_t it);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic [31:0] small_val(int bits);
        return 32'(signed'($urandom_range((1 << bits) - 1)) - (1 << (bits - 1)));
    endfunction

    function automatic pair_t random_pair();
        pair_t it;
        int    kind;
        kind = $urandom_range(99);
        for (int i = 0; i < NIN; i++) it[i] = $urandom;
        if (kind < 60) begin
            // plausible bodies: moderate positions, speeds and masses
            for (int i = 0; i < 2*NAX + NAX; i++) it[i] = small_val($urandom_range(4, 24));
            it[FLD_M1] = $urandom_range(1, 1 << $urandom_range(1, 24));
            it[FLD_M2] = $urandom_range(1, 1 << $urandom_range(1, 24));
        end
        case ($urandom_range(9))
            0: for (int i = 0; i < NAX; i++) it[i] = '0;
            1: begin it[FLD_M1] = '0; it[FLD_M2] = '0; end
            2: it[FLD_M1 + $urandom_range(1)] = '0;
            3: it[$urandom_range(NAX - 1)] = '0;
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_directed();
        pair_t it;
        // zero separation and zero total mass
        it = '0; send_pair(it);
        for (int i = 0; i < NIN; i++) it[i] = $urandom;
        for (int i = 0; i < NAX; i++) it[i] = '0;
        send_pair(it);
        for (int i = 0; i < NIN; i++) it[i] = $urandom;
        it[FLD_M1] = '0; it[FLD_M2] = '0;
        send_pair(it);
        // head-on, equal masses along x: velocities swap
        it = '0;
        it[0] = 32'h0001_0000; it[3] = 32'hFFFF_0000; it[6] = 32'h0001_0000;
        it[FLD_M1] = 32'h0001_0000; it[FLD_M2] = 32'h0001_0000;
        send_pair(it);
        // one body massless
        it[FLD_M1] = '0; send_pair(it);
        it[FLD_M1] = 32'h0001_0000; it[FLD_M2] = '0; send_pair(it);
        // oblique contact with tangential parts kept
        it = '0;
        it[0] = 32'h0003_0000; it[1] = 32'h0004_0000; it[2] = 32'hFFFE_0000;
        it[3] = 32'h0002_8000; it[4] = 32'hFFFF_4000; it[5] = 32'h0000_1000;
        it[6] = 32'hFFFD_0000; it[7] = 32'h0001_0000; it[8] = 32'h0005_0000;
        it[FLD_M1] = 32'h0002_0000; it[FLD_M2] = 32'h0000_8000;
        send_pair(it);
        // field extremes: saturation and correction cap
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 2*NAX + NAX; i++)
                it[i] = (((k >> (i % 2)) ^ (i / NAX)) & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            it[FLD_M1] = (k & 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            it[FLD_M2] = (k & 2) ? 32'hFFFF_FFFF : 32'h0000_0001;
            send_pair(it);
        end
        for (int i = 0; i < NIN; i++) it[i] = 32'hFFFF_FFFF;
        send_pair(it);
        for (int i = 0; i < NIN; i++) it[i] = 32'h8000_0000;
        send_pair(it);
        for (int i = 0; i < NIN; i++) it[i] = 32'h0000_0001;
        send_pair(it);
        // tiny separation, huge velocities
        it = '0;
        it[2] = 32'h0000_0001; it[5] = 32'h7FFF_FFFF; it[8] = 32'h8000_0000;
        it[FLD_M1] = 32'hFFFF_FFFF; it[FLD_M2] = 32'h0000_0001;
        send_pair(it);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_directed();
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 27 : (ph == 1) ? 47 : 0;
            rx_idle = (ph == 0) ? 47 : (ph == 1) ? 27 : 0;
            for (int n = 0; n < 500; n++) begin
                // fill the pipe against a blocked output
                if (n == 100 && ph != 1) stall_left = 300;
                if (n == 300) drain();
                send_pair(random_pair());
            end
            drain();
        end
        if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ecr_pkg.sv
sv/elastic_collision_response_core.sv
dv/tb_top.sv
